### design/tds_pkg.sv
// Shared types, constants and a helper function of the tridiagonal system solver.
package tds_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned STAT_W = 2;

  // Status codes carried on each result beat.
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_PIVOT = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_MANY   = 2'd2;

  // Operand pair for the shared multiplier.
  typedef enum logic [1:0] {
    MS_C_PREV = 2'd0,
    MS_G_PREV = 2'd1,
    MS_C_X    = 2'd2
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     rd_fwd;
    logic     rd_bs;
    logic     div_fwd;
    logic     div_bs;
    logic     m_load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     p_load;
    logic     wr;
    logic     bs_init;
    logic     r_dec;
    logic     out_load;
    logic     end_run;
  } tds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic first;
    logic prev_zero;
    logic last;
    logic err_nz;
    logic row_zero;
    logic div_rdy;
    logic out_free;
  } tds_stat_t;

  // Saturating v - t, with t already scaled back to the fraction grid.
  function automatic logic signed [DATA_W-1:0] sub_sat(logic signed [DATA_W-1:0] v,
                                                       logic signed [63:0] t);
    logic signed [64:0] diff;
    diff = {{33{v[DATA_W-1]}}, v} - {t[63], t};
    if (!diff[64] && (diff[63:31] != '0)) begin
      return 32'sh7fff_ffff;
    end else if (diff[64] && (diff[63:31] != '1)) begin
      return 32'sh8000_0000;
    end
    return diff[31:0];
  endfunction

endpackage

### design/tds_div.sv
// Iterative restoring divider for the saturated fixed-point quotient.
module tds_div import tds_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] num_i,
  input  logic signed [DATA_W-1:0] den_i,
  output logic                     rdy_o,
  output logic signed [DATA_W-1:0] quo_o
);

  localparam int unsigned NB = DATA_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [NB-1:0]     dvd_q;
  logic [DATA_W-1:0] dmag_q;
  logic [DATA_W-1:0] rem_q;
  logic [CW-1:0]     cnt_q;
  logic              neg_q;
  logic              rdy_q;
  logic [DATA_W:0]   nx, dx, nmag, dmag;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  // Magnitudes of the operands; the most negative value needs the extra bit.
  assign nx   = {num_i[DATA_W-1], num_i};
  assign dx   = {den_i[DATA_W-1], den_i};
  assign nmag = num_i[DATA_W-1] ? ((DATA_W+1)'(0) - nx) : nx;
  assign dmag = den_i[DATA_W-1] ? ((DATA_W+1)'(0) - dx) : dx;

  // One quotient bit per cycle.
  assign rem_sh = {rem_q, dvd_q[NB-1]};
  assign ge     = rem_sh >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rdy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= CW'(NB);
      rdy_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      rdy_q <= (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {nmag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
      dmag_q <= dmag[DATA_W-1:0];
      rem_q  <= '0;
      neg_q  <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DATA_W'(rem_sh - {1'b0, dmag_q}) : rem_sh[DATA_W-1:0];
      dvd_q <= {dvd_q[NB-2:0], ge};
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    if (neg_q) begin
      if (dvd_q > NB'(33'h0_8000_0000)) begin
        quo_o = 32'sh8000_0000;
      end else begin
        quo_o = DATA_W'(32'd0 - dvd_q[DATA_W-1:0]);
      end
    end else begin
      if (dvd_q > NB'(33'h0_7fff_ffff)) begin
        quo_o = 32'sh7fff_ffff;
      end else begin
        quo_o = dvd_q[DATA_W-1:0];
      end
    end
  end

  assign rdy_o = rdy_q;

endmodule

### design/tds_ctrl.sv
// Controller state machine sequencing elimination and back substitution.
module tds_ctrl import tds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tds_stat_t stat_i,
  output tds_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_FRD   = 12'b0000_0000_0010,
    S_FCHK  = 12'b0000_0000_0100,
    S_FDIV  = 12'b0000_0000_1000,
    S_MULP  = 12'b0000_0001_0000,
    S_MULG  = 12'b0000_0010_0000,
    S_WRITE = 12'b0000_0100_0000,
    S_FIN   = 12'b0000_1000_0000,
    S_BRD   = 12'b0001_0000_0000,
    S_BMUL  = 12'b0010_0000_0000,
    S_BDIV  = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and the command of each step.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.full) begin
            state_d = S_FIN;
          end else if (stat_i.first) begin
            state_d = S_MULP;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        cmd_o.rd_fwd = 1'b1;
        state_d      = S_FCHK;
      end
      S_FCHK: begin
        if (stat_i.prev_zero) begin
          state_d = S_MULP;
        end else begin
          cmd_o.div_fwd = 1'b1;
          state_d       = S_FDIV;
        end
      end
      S_FDIV: begin
        if (stat_i.div_rdy) begin
          cmd_o.m_load = 1'b1;
          state_d      = S_MULP;
        end
      end
      S_MULP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_C_PREV;
        state_d       = S_MULG;
      end
      S_MULG: begin
        cmd_o.p_load  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_G_PREV;
        state_d       = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.last) begin
          state_d = S_IDLE;
        end else if (stat_i.err_nz) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.bs_init = 1'b1;
          state_d       = S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.rd_bs = 1'b1;
        state_d     = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_C_X;
        state_d       = S_BDIV;
      end
      S_BDIV: begin
        cmd_o.div_bs = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free && (stat_i.err_nz || stat_i.div_rdy)) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.err_nz || stat_i.row_zero) begin
            cmd_o.end_run = 1'b1;
            state_d       = S_IDLE;
          end else begin
            cmd_o.r_dec = 1'b1;
            state_d     = S_BRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/tds_datapath.sv
// Datapath: row stores, shared multiplier, divider and the result register.
module tds_datapath import tds_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tds_cmd_t                 cmd_i,
  output tds_stat_t                stat_o,
  input  logic signed [DATA_W-1:0] sub_diag_i,
  input  logic signed [DATA_W-1:0] main_diag_i,
  input  logic signed [DATA_W-1:0] super_diag_i,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] solution_value_o,
  output logic [ROW_W-1:0]         row_index_o,
  output logic                     last_result_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);

  // Stores of pivots, reduced right-hand values and upper coefficients.
  logic signed [DATA_W-1:0] pivot_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] rhs_mem   [MAX_ROWS];
  logic signed [DATA_W-1:0] upper_mem [MAX_ROWS];

  logic signed [DATA_W-1:0] a_q, b_q, c_q, d_q, m_q, p_q, x_q;
  logic signed [DATA_W-1:0] rd_p_q, rd_g_q, rd_c_q;
  logic signed [63:0]       prod_q;
  logic                     last_q, first_q, top_q;
  logic [CW-1:0]            rows_q;
  logic [STAT_W-1:0]        err_q;
  logic [AW-1:0]            r_q;
  logic                     out_valid_q, out_last_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic [ROW_W-1:0]         out_row_q;
  logic [STAT_W-1:0]        out_stat_q;

  logic signed [63:0]       prod_sh;
  logic signed [DATA_W-1:0] g_new, bs_num, mul_a, mul_b, div_num, div_den, quo;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic                     div_start, div_rdy;

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign g_new   = sub_sat(d_q, prod_sh);
  assign bs_num  = top_q ? rd_g_q : sub_sat(rd_g_q, prod_sh);
  assign wr_addr = rows_q[AW-1:0];
  assign rd_addr = cmd_i.rd_bs ? r_q : AW'(rows_q - 1'b1);

  // Row counter, error flag and the latched input row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
      err_q  <= ST_OK;
    end else if (cmd_i.end_run || (cmd_i.bs_init)) begin
      if (cmd_i.end_run) begin
        rows_q <= '0;
        err_q  <= ST_OK;
      end
    end else if (cmd_i.accept && (rows_q >= CW'(MAX_ROWS))) begin
      err_q <= ST_TOO_MANY;
    end else if (cmd_i.wr) begin
      rows_q <= rows_q + 1'b1;
      if ((p_q == '0) && (err_q != ST_TOO_MANY)) begin
        err_q <= ST_ZERO_PIVOT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q     <= sub_diag_i;
      b_q     <= main_diag_i;
      c_q     <= super_diag_i;
      d_q     <= rhs_value_i;
      last_q  <= last_row_i;
      first_q <= (rows_q == '0);
      m_q     <= '0;
    end else if (cmd_i.m_load) begin
      m_q <= quo;
    end
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      pivot_mem[wr_addr] <= p_q;
      rhs_mem[wr_addr]   <= g_new;
      upper_mem[wr_addr] <= last_q ? '0 : c_q;
    end
    if (cmd_i.rd_fwd || cmd_i.rd_bs) begin
      rd_p_q <= pivot_mem[rd_addr];
      rd_g_q <= rhs_mem[rd_addr];
      rd_c_q <= upper_mem[rd_addr];
    end
  end

  // Shared multiplier; the first row multiplies by zero.
  always_comb begin
    mul_a = m_q;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MS_C_PREV: mul_b = first_q ? '0 : rd_c_q;
      MS_G_PREV: mul_b = first_q ? '0 : rd_g_q;
      MS_C_X: begin
        mul_a = rd_c_q;
        mul_b = x_q;
      end
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.p_load) begin
      p_q <= sub_sat(b_q, prod_sh);
    end
  end

  // Divider shared by elimination and back substitution.
  assign div_start = cmd_i.div_fwd || cmd_i.div_bs;
  assign div_num   = cmd_i.div_bs ? bs_num : a_q;
  assign div_den   = rd_p_q;

  tds_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .rdy_o  (div_rdy),
    .quo_o  (quo)
  );

  // Back substitution row pointer and the carried solution.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
    end else if (cmd_i.out_load && (err_q == ST_OK)) begin
      x_q <= quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bs_init) begin
      r_q   <= AW'(rows_q - 1'b1);
      top_q <= 1'b1;
    end else if (cmd_i.r_dec) begin
      r_q   <= r_q - 1'b1;
      top_q <= 1'b0;
    end
  end

  // Result register: holds one beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (err_q != ST_OK) begin
        out_val_q  <= '0;
        out_row_q  <= '0;
        out_last_q <= 1'b1;
        out_stat_q <= err_q;
      end else begin
        out_val_q  <= quo;
        out_row_q  <= ROW_W'(r_q);
        out_last_q <= (r_q == '0);
        out_stat_q <= ST_OK;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign solution_value_o = out_val_q;
  assign row_index_o      = out_row_q;
  assign last_result_o    = out_last_q;
  assign status_o         = out_stat_q;

  // Status toward the controller.
  assign stat_o.full      = (rows_q >= CW'(MAX_ROWS));
  assign stat_o.first     = (rows_q == '0);
  assign stat_o.prev_zero = (rd_p_q == '0);
  assign stat_o.last      = last_q;
  assign stat_o.err_nz    = (err_q != ST_OK);
  assign stat_o.row_zero  = (r_q == '0);
  assign stat_o.div_rdy   = div_rdy;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

### design/tridiagonal_system_solver.sv
// Top level of the tridiagonal system solver.
// Solves one tridiagonal system by the Thomas algorithm in signed fixed point with
// FRAC_BITS fraction bits. Rows enter one beat at a time, row 0 first; each row is
// eliminated as it arrives; row 0, a row after a zero pivot and a dropped row skip the
// bit-serial divider, and every other row waits for it. The row marked last starts back
// substitution, which sends one result beat per row from the last row down to row 0,
// each beat waiting for the divider and, when the output is stalled, for the output.
// A zero pivot or more than MAX_ROWS rows yields a single result beat with the status
// code. The block takes a new row while the final result beat still waits at the output.
module tridiagonal_system_solver import tds_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sub_diag_i,
  input  logic signed [DATA_W-1:0] main_diag_i,
  input  logic signed [DATA_W-1:0] super_diag_i,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] solution_value_o,
  output logic [ROW_W-1:0]         row_index_o,
  output logic                     last_result_o,
  output logic [STAT_W-1:0]        status_o
);

  tds_cmd_t  cmd;
  tds_stat_t stat;

  tds_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tds_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sub_diag_i      (sub_diag_i),
    .main_diag_i     (main_diag_i),
    .super_diag_i    (super_diag_i),
    .rhs_value_i     (rhs_value_i),
    .last_row_i      (last_row_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .solution_value_o(solution_value_o),
    .row_index_o     (row_index_o),
    .last_result_o   (last_result_o),
    .status_o        (status_o)
  );

endmodule

### design/tds_checker.sv
// Port-level checker of the tridiagonal system solver and its bind.
module tds_checker import tds_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] solution_value_o,
  input logic [ROW_W-1:0]         row_index_o,
  input logic                     last_result_o,
  input logic [STAT_W-1:0]        status_o
);

  // A stalled result beat keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(solution_value_o))
    else $error("stalled result beat changed");

  // An error beat always closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_result_o)
    else $error("error beat without end of run");

  // An error beat carries a zero value at row 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (solution_value_o == '0) && (row_index_o == '0))
    else $error("error beat with payload");

  // Only row 0 ends a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> (row_index_o == '0))
    else $error("end of run on a row other than 0");

endmodule

bind tridiagonal_system_solver tds_checker u_tds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .solution_value_o(solution_value_o),
  .row_index_o     (row_index_o),
  .last_result_o   (last_result_o),
  .status_o        (status_o)
);
